// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the RTL files.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/dpdd_pkg.sv -----
// ---------------------------------------------------------------------------
// Dial pulse digit decoder package
// Register indexes, reset values and fixed constants of the decoder.
// ---------------------------------------------------------------------------
package dpdd_pkg;

	localparam int COUNT_WIDTH_DEF = 8;
	localparam int CFG_W           = 8;
	localparam int CFG_IDX_W       = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PULSE_MIN      = 3'd0,
		CFG_PULSE_MAX      = 3'd1,
		CFG_DIGIT_GAP_MIN  = 3'd2,
		CFG_DIGIT_GAP_MAX  = 3'd3,
		CFG_NUMBER_GAP_MIN = 3'd4
	} cfg_reg_t;

	localparam logic [CFG_W-1:0] PULSE_MIN_RST      = 8'd8;
	localparam logic [CFG_W-1:0] PULSE_MAX_RST      = 8'd12;
	localparam logic [CFG_W-1:0] DIGIT_GAP_MIN_RST  = 8'd20;
	localparam logic [CFG_W-1:0] DIGIT_GAP_MAX_RST  = 8'd39;
	localparam logic [CFG_W-1:0] NUMBER_GAP_MIN_RST = 8'd40;

	localparam logic [3:0] PULSES_MAX = 4'd15;
	localparam logic [3:0] TEN_PULSES = 4'd10;

	localparam logic EVT_DIGIT      = 1'b0;
	localparam logic EVT_NUMBER_END = 1'b1;

endpackage

// ----- hw/rtl/dial_pulse_digit_decoder.sv -----
// ---------------------------------------------------------------------------
// Dial pulse digit decoder
// Counts high and low ticks of a sampled pulse line and reports dialled
// digits and number terminators.
// ---------------------------------------------------------------------------
// Usage: one line sample per request arrives on the input channel
// (in_valid, in_stall, line_level). A sample is taken at an edge where
// in_valid is high and in_stall low; it lands in an input register and is
// decoded when that register advances, when the counters and the result
// register are updated together. A sample causes no result or one result
// on the output channel (out_valid, out_stall, event_kind, digit_value,
// dial_fault), which is driven from the result register.
// Throughput is one sample per clock cycle unless the receiver stalls;
// the single update of the run counters sets that figure. When the receiver
// stalls, the result is held and the input register keeps its sample, so
// in_stall rises until the result is taken; a sample that gives no result
// still needs the result register to be free, since it may clear it.
// Configuration writes (cfg_valid, cfg_ready, cfg_index, cfg_data) are
// always ready; an index beyond the register list is ignored. Reset loads
// the default windows and clears the counters and both channels.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dial_pulse_digit_decoder
	import dpdd_pkg::*;
#(
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 line_level,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 event_kind,
	output logic [3:0]           digit_value,
	output logic                 dial_fault,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
	localparam logic [COUNT_WIDTH-1:0] RUN_MAX = {COUNT_WIDTH{1'b1}};

	logic [CFG_W-1:0] pulse_min_q, pulse_max_q;
	logic [CFG_W-1:0] digit_gap_min_q, digit_gap_max_q, number_gap_min_q;

	logic valid_s1, level_s1;
	logic adv;

	logic                   last_level_q;
	logic [COUNT_WIDTH-1:0] high_run_q, low_run_q;
	logic [3:0]             pulses_q;
	logic                   fault_q;

	logic                   high_run_n, last_level_n;
	logic [COUNT_WIDTH-1:0] high_n, low_n;
	logic [3:0]             pulses_n;
	logic                   fault_n;
	logic                   emit_digit, emit_end;
	logic [3:0]             digit_n;
	logic                   error_n;

	logic                   out_valid_q, event_kind_q, dial_fault_q;
	logic [3:0]             digit_value_q;

	// Configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_min_q      <= PULSE_MIN_RST;
			pulse_max_q      <= PULSE_MAX_RST;
			digit_gap_min_q  <= DIGIT_GAP_MIN_RST;
			digit_gap_max_q  <= DIGIT_GAP_MAX_RST;
			number_gap_min_q <= NUMBER_GAP_MIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PULSE_MIN:      pulse_min_q      <= cfg_data;
				CFG_PULSE_MAX:      pulse_max_q      <= cfg_data;
				CFG_DIGIT_GAP_MIN:  digit_gap_min_q  <= cfg_data;
				CFG_DIGIT_GAP_MAX:  digit_gap_max_q  <= cfg_data;
				CFG_NUMBER_GAP_MIN: number_gap_min_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Input register; it drains whenever the result register can take a result.
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			level_s1 <= line_level;
		end
	end

	// Decode of one sample
	always_comb begin
		high_n       = high_run_q;
		low_n        = low_run_q;
		pulses_n     = pulses_q;
		fault_n      = fault_q;
		high_run_n   = 1'b0;
		emit_digit   = 1'b0;
		emit_end     = 1'b0;
		last_level_n = level_s1;
		if (level_s1) begin
			high_n = (high_run_q == RUN_MAX) ? high_run_q : high_run_q + 1'b1;
			low_n  = '0;
		end else begin
			low_n = (low_run_q == RUN_MAX) ? low_run_q : low_run_q + 1'b1;
			if (last_level_q) begin
				// A falling edge closes one pulse; check its high width.
				high_run_n = (CMP_W'(high_run_q) < CMP_W'(pulse_min_q)) ||
				             (CMP_W'(high_run_q) > CMP_W'(pulse_max_q));
				fault_n    = fault_q | high_run_n;
				pulses_n   = (pulses_q == PULSES_MAX) ? pulses_q : pulses_q + 1'b1;
				high_n     = '0;
			end
			emit_digit = (pulses_n != 4'd0) &&
			             (CMP_W'(low_n) >= CMP_W'(digit_gap_min_q)) &&
			             (CMP_W'(low_n) <= CMP_W'(digit_gap_max_q));
			// The terminator is only considered on a tick that gives no digit.
			emit_end   = !emit_digit && (CMP_W'(low_n) >= CMP_W'(number_gap_min_q));
		end
		digit_n = (pulses_n == TEN_PULSES) ? 4'd0 : pulses_n;
		error_n = fault_n;
		if (emit_digit || emit_end) begin
			pulses_n = 4'd0;
			fault_n  = 1'b0;
			low_n    = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			high_run_q   <= '0;
			low_run_q    <= '0;
			pulses_q     <= 4'd0;
			fault_q      <= 1'b0;
		end else if (adv) begin
			last_level_q <= last_level_n;
			high_run_q   <= high_n;
			low_run_q    <= low_n;
			pulses_q     <= pulses_n;
			fault_q      <= fault_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && (emit_digit || emit_end)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit_digit) begin
			event_kind_q  <= EVT_DIGIT;
			digit_value_q <= digit_n;
			dial_fault_q  <= error_n;
		end else if (adv && emit_end) begin
			event_kind_q  <= EVT_NUMBER_END;
			digit_value_q <= 4'd0;
			dial_fault_q  <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign event_kind  = event_kind_q;
	assign digit_value = digit_value_q;
	assign dial_fault  = dial_fault_q;

	`ASSERT_CLK(a_end_fields_zero, clk, arst_n,
		(out_valid_q && event_kind_q == EVT_NUMBER_END) |->
			(digit_value_q == 4'd0 && !dial_fault_q),
		"number terminator carries a digit or an error")
	`ASSERT_CLK(a_result_clears_state, clk, arst_n,
		(adv && (emit_digit || emit_end)) |=>
			(low_run_q == '0 && pulses_q == 4'd0 && !fault_q && out_valid_q),
		"state not cleared after a result")
	`ASSERT_NEVER(a_no_result_when_high, clk, arst_n,
		adv && level_s1 && (emit_digit || emit_end),
		"result raised while the line is high")

endmodule

// ----- verif/tb_dial_pulse_digit_decoder.sv -----
// ---------------------------------------------------------------------------
// Dial pulse digit decoder testbench
// Feeds line samples through the request channel, tracks the decoder
// state in a local model and checks each digit and number-end result in
// order. Directed cases cover the window edges and saturation; random
// dialling under changing windows and flow control follows.
// ---------------------------------------------------------------------------
module tb_dial_pulse_digit_decoder
	import dpdd_pkg::*;
();

	localparam int RUN_W         = COUNT_WIDTH_DEF;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 8;

	typedef struct packed {
		logic       kind;
		logic [3:0] digit;
		logic       fault;
	} dial_event_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_BURSTY
	} stall_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 line_level;
	logic                 out_valid;
	logic                 out_stall;
	logic                 event_kind;
	logic [3:0]           digit_value;
	logic                 dial_fault;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Local copy of the windows and of the decoder state.
	logic [CFG_W-1:0] win_pulse_min;
	logic [CFG_W-1:0] win_pulse_max;
	logic [CFG_W-1:0] win_digit_min;
	logic [CFG_W-1:0] win_digit_max;
	logic [CFG_W-1:0] win_number_gap;
	logic             last_seen;
	logic [RUN_W-1:0] high_len;
	logic [RUN_W-1:0] low_len;
	logic [3:0]       pulse_tally;
	logic             width_bad;

	dial_event_t pending_events[$];
	int          fail_count;
	int          samples_sent;
	int          burst_left;
	int          idle_cycles;
	stall_mode_t stall_mode;
	logic [5:0]  stall_age;

	dial_pulse_digit_decoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.line_level  (line_level),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.event_kind  (event_kind),
		.digit_value (digit_value),
		.dial_fault  (dial_fault),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advances the local decoder by one accepted sample.
	function automatic void decode_sample(input logic level);
		dial_event_t ev;
		logic        emit;
		emit = 1'b0;
		ev   = '0;
		if (level) begin
			if (high_len != '1)
				high_len++;
			low_len = '0;
		end else begin
			if (low_len != '1)
				low_len++;
			if (last_seen) begin
				if (high_len < win_pulse_min || high_len > win_pulse_max)
					width_bad = 1'b1;
				if (pulse_tally != PULSES_MAX)
					pulse_tally++;
				high_len = '0;
			end
			// A digit takes priority; the terminator is only looked at otherwise.
			if (pulse_tally != 4'd0 && low_len >= win_digit_min &&
					low_len <= win_digit_max) begin
				ev.kind  = EVT_DIGIT;
				ev.digit = (pulse_tally == TEN_PULSES) ? 4'd0 : pulse_tally;
				ev.fault = width_bad;
				emit     = 1'b1;
			end else if (low_len >= win_number_gap) begin
				ev.kind = EVT_NUMBER_END;
				emit    = 1'b1;
			end
			if (emit) begin
				pending_events.push_back(ev);
				pulse_tally = '0;
				width_bad   = 1'b0;
				low_len     = '0;
			end
		end
		last_seen = level;
	endfunction

	// Sends one sample request. Starts and ends at a falling edge; the
	// sender may idle between bursts of random length.
	task automatic send_sample(input logic level);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			repeat (gap) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		burst_left--;
		in_valid   <= 1'b1;
		line_level <= level;
		do
			@(posedge clk);
		while (in_stall);
		decode_sample(level);
		samples_sent++;
		@(negedge clk);
	endtask

	task automatic send_run(input logic level, input int count);
		repeat (count)
			send_sample(level);
	endtask

	// Dials a number of pulses of one width; the low after the last pulse
	// is left to the caller.
	task automatic dial_pulses(input int count, input int high_w, input int low_w);
		int k;
		for (k = 0; k < count; k++) begin
			send_run(1'b1, high_w);
			if (k < count - 1)
				send_run(1'b0, low_w);
		end
	endtask

	// Leaves the block empty, allowing for a sample still in flight that
	// gives no result.
	task automatic quiesce();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES)
			@(negedge clk);
	endtask

	// Leaves cfg_valid high on return; the caller lowers it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_PULSE_MIN:      win_pulse_min  = data;
			CFG_PULSE_MAX:      win_pulse_max  = data;
			CFG_DIGIT_GAP_MIN:  win_digit_min  = data;
			CFG_DIGIT_GAP_MAX:  win_digit_max  = data;
			CFG_NUMBER_GAP_MIN: win_number_gap = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_windows(input logic [CFG_W-1:0] pmin, input logic [CFG_W-1:0] pmax,
			input logic [CFG_W-1:0] dmin, input logic [CFG_W-1:0] dmax,
			input logic [CFG_W-1:0] ngap, input bit stray_write);
		quiesce();
		write_reg(CFG_PULSE_MIN, pmin);
		write_reg(CFG_PULSE_MAX, pmax);
		write_reg(CFG_DIGIT_GAP_MIN, dmin);
		write_reg(CFG_DIGIT_GAP_MAX, dmax);
		write_reg(CFG_NUMBER_GAP_MIN, ngap);
		// An index past the register list must leave every window alone.
		if (stray_write)
			write_reg(CFG_IDX_W'($urandom_range(CFG_NUMBER_GAP_MIN + 1, 2 ** CFG_IDX_W - 1)),
					CFG_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	task automatic dial_random();
		int pulses;
		int high_w;
		int low_w;
		int gap;
		int k;
		pulses = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 18) : $urandom_range(1, 10);
		for (k = 0; k < pulses; k++) begin
			if ($urandom_range(0, 7) == 0)
				high_w = $urandom_range(1, win_pulse_max + 3);
			else
				high_w = $urandom_range(win_pulse_min, win_pulse_max);
			if (high_w < 1)
				high_w = 1;
			if (high_w > 48)
				high_w = 48;
			send_run(1'b1, high_w);
			if (k < pulses - 1) begin
				low_w = $urandom_range(1, (win_digit_min > 2) ? win_digit_min - 1 : 1);
				if (low_w > 48)
					low_w = 48;
				send_run(1'b0, low_w);
			end
		end
		gap = $urandom_range(win_digit_min, win_digit_max);
		if ($urandom_range(0, 3) == 0)
			gap += win_number_gap + $urandom_range(0, 2);
		if (gap < 1)
			gap = 1;
		if (gap > 300)
			gap = 300;
		send_run(1'b0, gap);
	endtask

	task automatic test_default_windows();
		dial_pulses(3, 10, 5);
		send_run(1'b0, 25);
		send_run(1'b0, 40);
		dial_pulses(1, 13, 0);
		send_run(1'b0, 20);
		dial_pulses(1, 7, 0);
		send_run(1'b0, 60);
	endtask

	task automatic test_pulse_counts();
		set_windows(8'd1, 8'd2, 8'd3, 8'd4, 8'd6, 1'b1);
		dial_pulses(10, 2, 1);
		send_run(1'b0, 3);
		dial_pulses(17, 1, 2);
		send_run(1'b0, 4);
		dial_pulses(2, 3, 1);
		send_run(1'b0, 8);
	endtask

	task automatic test_run_saturation();
		// A saturated high run of all ones fits a window pinned at the top.
		set_windows(8'd255, 8'd255, 8'd3, 8'd4, 8'd6, 1'b0);
		send_run(1'b1, 256);
		send_run(1'b0, 3);
	endtask

	task automatic test_digit_and_terminator();
		set_windows(8'd1, 8'd4, 8'd5, 8'd6, 8'd5, 1'b0);
		dial_pulses(1, 2, 0);
		send_run(1'b0, 10);
		// Number gap shorter than the digit gap: the terminator wins.
		set_windows(8'd1, 8'd4, 8'd3, 8'd4, 8'd2, 1'b0);
		dial_pulses(1, 2, 0);
		send_run(1'b0, 4);
	endtask

	task automatic test_inverted_windows();
		set_windows(8'd5, 8'd2, 8'd6, 8'd3, 8'd10, 1'b0);
		dial_pulses(2, 3, 1);
		send_run(1'b0, 12);
	endtask

	task automatic test_register_extremes();
		// A zero number gap ends a number on every low sample.
		set_windows(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1);
		dial_pulses(2, 1, 1);
		send_run(1'b0, 3);
		set_windows(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1);
		dial_pulses(1, 4, 0);
		send_run(1'b0, 255);
	endtask

	task automatic test_random_dialling();
		int phase;
		int target;
		for (phase = 0; phase < 3; phase++) begin
			if (phase % 3 == 2) begin
				set_windows(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
						CFG_W'($urandom), CFG_W'($urandom), 1'($urandom_range(0, 1)));
			end else begin
				win_pulse_min  = CFG_W'($urandom_range(1, 6));
				win_pulse_max  = CFG_W'(win_pulse_min + $urandom_range(0, 4));
				win_digit_min  = CFG_W'($urandom_range(2, 12));
				win_digit_max  = CFG_W'(win_digit_min + $urandom_range(0, 10));
				win_number_gap = CFG_W'(win_digit_max + $urandom_range(1, 12));
				set_windows(win_pulse_min, win_pulse_max, win_digit_min, win_digit_max,
						win_number_gap, 1'($urandom_range(0, 1)));
			end
			target = samples_sent + 60;
			while (samples_sent < target) begin
				if ($urandom_range(0, 5) == 0)
					repeat ($urandom_range(1, 12))
						send_sample(1'($urandom_range(0, 1)));
				else
					dial_random();
			end
		end
	endtask

	// The receiver picks a new stall pattern each time the 6-bit stall_age counter wraps.
	always @(negedge clk) begin
		stall_age = stall_age + 6'd1;
		if (stall_age == 6'd0)
			stall_mode = stall_mode_t'($urandom_range(0, 3));
		case (stall_mode)
			STALL_NONE:   out_stall <= 1'b0;
			STALL_LIGHT:  out_stall <= ($urandom_range(0, 9) < 2);
			STALL_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
			STALL_BURSTY: out_stall <= (stall_age[3:0] >= 4'd10);
			default:      out_stall <= 1'b0;
		endcase
	end

	always @(posedge clk) begin : check_results
		dial_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected result, kind %0d digit %0d error %0d",
						$time, event_kind, digit_value, dial_fault);
				fail_count++;
			end else begin
				want = pending_events.pop_front();
				if (event_kind !== want.kind) begin
					$display("%0t: event_kind expected %0d, got %0d", $time, want.kind, event_kind);
					fail_count++;
				end
				if (digit_value !== want.digit) begin
					$display("%0t: digit_value expected %0d, got %0d",
							$time, want.digit, digit_value);
					fail_count++;
				end
				if (dial_fault !== want.fault) begin
					$display("%0t: dial_fault expected %0d, got %0d",
							$time, want.fault, dial_fault);
					fail_count++;
				end
			end
		end
	end

	// Ends the run if no request moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		line_level     = 1'b0;
		out_stall      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		win_pulse_min  = PULSE_MIN_RST;
		win_pulse_max  = PULSE_MAX_RST;
		win_digit_min  = DIGIT_GAP_MIN_RST;
		win_digit_max  = DIGIT_GAP_MAX_RST;
		win_number_gap = NUMBER_GAP_MIN_RST;
		last_seen      = 1'b0;
		high_len       = '0;
		low_len        = '0;
		pulse_tally    = '0;
		width_bad      = 1'b0;
		fail_count     = 0;
		samples_sent   = 0;
		burst_left     = 0;
		idle_cycles    = 0;
		stall_mode     = STALL_NONE;
		stall_age      = '0;
		repeat (4)
			@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_default_windows();
		test_pulse_counts();
		test_run_saturation();
		test_digit_and_terminator();
		test_inverted_windows();
		test_register_extremes();
		test_random_dialling();

		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- dial_pulse_digit_decoder.f -----
+incdir+hw/rtl
hw/rtl/dpdd_pkg.sv
hw/rtl/dial_pulse_digit_decoder.sv
verif/tb_dial_pulse_digit_decoder.sv
